/* rtl/core/b64d_pkg.sv */
// b64d_pkg: shared types, codes and the character map for the base64 decoder.
// No dependencies; used by b64d_decode and the top level.
`timescale 1ns / 1ps

package b64d_pkg;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  localparam int unsigned SEXTET_W = 6;
  localparam int unsigned HELD_W   = 3 * SEXTET_W;

  // Decoder state carried from one character to the next.
  typedef struct packed {
    logic              stopped;
    logic [1:0]        symbol_count;
    logic [HELD_W-1:0] held_sextets;
  } dec_state_t;

  // Results caused by one item: up to three, first in b0.
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       has_bytes;
    logic       last;
  } res_group_t;

  // Map a character to {invalid, sextet}.
  function automatic logic [SEXTET_W:0] sextet_of(input logic [7:0] ch);
    logic [SEXTET_W:0] r;
    r = {1'b1, {SEXTET_W{1'b0}}};
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      r = {1'b0, 6'(ch - 8'h41)};
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      r = {1'b0, 6'(ch - 8'h61 + 8'd26)};
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b0, 6'(ch - 8'h30 + 8'd52)};
    end else if (ch == 8'h2B) begin
      r = {1'b0, 6'd62};
    end else if (ch == 8'h2F) begin
      r = {1'b0, 6'd63};
    end
    return r;
  endfunction

endpackage

/* rtl/core/base64_stream_decoder_top.sv */
// base64_stream_decoder_top: base64 character stream to byte stream.
// Depends on b64d_pkg and b64d_decode.
//
//   channel | handshake                  | payload
//   --------+----------------------------+----------------------------------
//   item    | item_valid / item_stall    | operation, character
//   result  | result_valid / result_stall| data_byte, byte_valid, last
//
// An accepted word lands in an input register; one pass of decode logic
// then updates the state and loads any results into a three-entry result
// register, from which the first result is offered.
// A new word is taken every cycle unless the decoded word still waits for
// room in that result register.
// A full group holds the result port for its three bytes, which drain while
// the next three characters retire, so dense input runs at one character
// per cycle while result_stall is low. An end word waits while earlier bytes
// drain; beyond that only result_stall holds the input.
// Synchronous reset clears the state and empties both registers.
`timescale 1ns / 1ps

module base64_stream_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       operation,
  input  logic [7:0] character,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] data_byte,
  output logic       byte_valid,
  output logic       last
);

  // input register
  logic       in_full;
  logic       in_op;
  logic [7:0] in_ch;

  // decoder state
  b64d_pkg::dec_state_t state;
  b64d_pkg::dec_state_t state_next;
  b64d_pkg::res_group_t group;

  // result register: bytes shift toward out_b0
  logic [1:0] out_cnt;
  logic [7:0] out_b0;
  logic [7:0] out_b1;
  logic [7:0] out_b2;
  logic       out_has_bytes;
  logic       out_last;

  logic take_in;
  logic take_out;
  logic room;
  logic consume;
  logic load;

  b64d_decode u_decode (
    .operation (in_op),
    .character (in_ch),
    .state_cur (state),
    .state_next(state_next),
    .group     (group)
  );

  assign take_out = result_valid && !result_stall;
  // result register frees up this cycle
  assign room     = (out_cnt == 2'd0) || (out_cnt == 2'd1 && take_out);
  // retire the held word: no results, or results fit
  assign consume  = in_full && (group.count == 2'd0 || room);
  assign load     = consume && (group.count != 2'd0);

  assign item_stall = in_full && !consume;
  assign take_in    = item_valid && !item_stall;

  assign result_valid = (out_cnt != 2'd0);
  assign data_byte    = out_b0;
  assign byte_valid   = out_has_bytes;
  assign last         = out_last && (out_cnt == 2'd1);

  // hold the incoming word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take_in) begin
      in_full <= 1'b1;
    end else if (consume) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_op <= operation;
      in_ch <= character;
    end
  end

  // advance decoder state once per retired word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (consume) begin
      state <= state_next;
    end
  end

  // load a new group, or drop the head byte once it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= 2'd0;
    end else if (load) begin
      out_cnt <= group.count;
    end else if (take_out) begin
      out_cnt <= out_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_b0        <= group.b0;
      out_b1        <= group.b1;
      out_b2        <= group.b2;
      out_has_bytes <= group.has_bytes;
      out_last      <= group.last;
    end else if (take_out) begin
      out_b0 <= out_b1;
      out_b1 <= out_b2;
    end
  end

endmodule

/* rtl/core/b64d_decode.sv */
// b64d_decode: combinational step for one item: classify, map, shift, emit.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_decode (
  input  logic                operation,
  input  logic [7:0]          character,
  input  b64d_pkg::dec_state_t state_cur,
  output b64d_pkg::dec_state_t state_next,
  output b64d_pkg::res_group_t group
);

  logic [b64d_pkg::SEXTET_W:0]             map;
  logic [b64d_pkg::HELD_W-1:0]             held;
  logic [b64d_pkg::HELD_W+b64d_pkg::SEXTET_W-1:0] word;

  assign map  = b64d_pkg::sextet_of(character);
  assign held = state_cur.held_sextets;
  assign word = {held, map[b64d_pkg::SEXTET_W-1:0]};

  always_comb begin
    state_next      = state_cur;
    group.count     = 2'd0;
    group.b0        = 8'd0;
    group.b1        = 8'd0;
    group.b2        = 8'd0;
    group.has_bytes = 1'b1;
    group.last      = 1'b0;
    if (operation == b64d_pkg::OP_END) begin
      // flush the partial group and return to the start state
      group.last = 1'b1;
      case (state_cur.symbol_count)
        2'd2: begin
          group.count = 2'd1;
          group.b0    = held[11:4];
        end
        2'd3: begin
          group.count = 2'd2;
          group.b0    = held[17:10];
          group.b1    = held[9:2];
        end
        default: begin
          group.count     = 2'd1;
          group.has_bytes = 1'b0;
        end
      endcase
      state_next = '0;
    end else if (!state_cur.stopped && character != b64d_pkg::CHAR_LF &&
                 character != b64d_pkg::CHAR_CR) begin
      if (map[b64d_pkg::SEXTET_W]) begin
        state_next.stopped = 1'b1;
      end else if (state_cur.symbol_count != 2'd3) begin
        state_next.held_sextets = word[b64d_pkg::HELD_W-1:0];
        state_next.symbol_count = state_cur.symbol_count + 2'd1;
      end else begin
        group.count = 2'd3;
        group.b0    = word[23:16];
        group.b1    = word[15:8];
        group.b2    = word[7:0];
        state_next.held_sextets = '0;
        state_next.symbol_count = 2'd0;
      end
    end
  end

endmodule

/* rtl/core/b64d_checker.sv */
// b64d_checker: port-level checks for base64_stream_decoder_top, and its bind.
// Depends on the top level's ports only.
`timescale 1ns / 1ps

module b64d_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_stall,
  input logic       result_valid,
  input logic       result_stall,
  input logic [7:0] data_byte,
  input logic       byte_valid,
  input logic       last
);

  // results stay offered while stalled
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(data_byte) && $stable(byte_valid) &&
      $stable(last))
    else $error("stalled result changed");

  // reset empties both sides
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("block not empty after reset");

  // an empty marker closes a string and carries a zero byte
  a_marker: assert property (@(posedge clk) disable iff (rst)
    result_valid && !byte_valid |-> last && data_byte == 8'd0)
    else $error("malformed empty marker");

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (
  .clk         (clk),
  .rst         (rst),
  .item_stall  (item_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .data_byte   (data_byte),
  .byte_valid  (byte_valid),
  .last        (last)
);
